### design/vgc_pkg.sv
// ----------------------------------------------------------------------------
// vgc_pkg - shared types and constants of the varint group codec
// Result kinds, operation codes and the result word handed between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package vgc_pkg;

	localparam int VALUE_W = 64;
	localparam logic [7:0] MARK_TOP = 8'h80;

	typedef enum logic {
		OP_DECODE = 1'b0,
		OP_ENCODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_VALUE    = 2'd1,
		KIND_BAD_MARK = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data_byte;
		logic [VALUE_W-1:0] value;
		logic               last;
	} result_t;

	typedef struct packed {
		logic busy;   // holding an encode
		logic valid;  // a byte word is on offer
	} enc_stat_t;

endpackage

`default_nettype wire

### design/vgc_enc.sv
// ----------------------------------------------------------------------------
// vgc_enc - byte-serial encoder
// Sizes the value, offers the marker byte, then shifts the big-endian
// payload out of a byte-wide shift register, one byte per taken word.
// ----------------------------------------------------------------------------
`default_nettype none

module vgc_enc #(
	parameter int GROUP_BYTES = 4,
	parameter int VALUE_BYTES = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [vgc_pkg::VALUE_W-1:0] value,
	input  wire logic                        take,
	output vgc_pkg::enc_stat_t               stat,
	output vgc_pkg::result_t                 res
);

	localparam int VW = 8 * VALUE_BYTES;
	localparam int LW = $clog2(8 * GROUP_BYTES + 1);

	typedef enum logic [2:0] {
		E_IDLE  = 3'b001,
		E_MARK  = 3'b010,
		E_BYTES = 3'b100
	} enc_state_t;

	enc_state_t    state_q;
	logic [VW-1:0] val_q;
	logic [3:0]    groups_q;
	logic [LW-1:0] cnt_q;

	logic [3:0]    sig;
	logic [3:0]    groups_d;
	logic [LW-1:0] len;
	logic [3:0]    skip;
	logic [VW-1:0] aligned;
	logic [7:0]    mark;
	logic          in_value_part;

	// significant bytes, then whole groups
	always_comb begin
		sig = 4'd1;
		for (int i = 0; i < VALUE_BYTES; i++) begin
			if (value[8*i +: 8] != 8'h00) begin
				sig = 4'(i + 1);
			end
		end
		groups_d = '0;
		for (int k = 0; k < 8; k++) begin
			if (int'(sig) > k * GROUP_BYTES) begin
				groups_d = groups_d + 4'd1;
			end
		end
	end

	// payload alignment: top byte of the register becomes the first sent
	always_comb begin
		len  = LW'(int'(groups_q) * GROUP_BYTES);
		skip = (len < LW'(VALUE_BYTES)) ? 4'(VALUE_BYTES - int'(len)) : 4'd0;
		aligned = val_q;
		for (int j = 0; j < VALUE_BYTES; j++) begin
			if (int'(skip) == j) begin
				aligned = val_q << (8 * j);
			end
		end
		mark = vgc_pkg::MARK_TOP >> (groups_q - 4'd1);
	end

	assign in_value_part = (cnt_q < LW'(VALUE_BYTES));

	always_comb begin
		res.kind  = vgc_pkg::KIND_BYTE;
		res.value = '0;
		if (state_q == E_MARK) begin
			res.data_byte = mark;
			res.last      = 1'b0;
		end else begin
			res.data_byte = in_value_part ? val_q[VW-1 -: 8] : 8'h00;
			res.last      = (cnt_q == '0);
		end
	end

	assign stat.busy  = (state_q != E_IDLE);
	assign stat.valid = (state_q == E_MARK) || (state_q == E_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (start) state_q <= E_MARK;
				end
				E_MARK: begin
					if (take) state_q <= E_BYTES;
				end
				E_BYTES: begin
					if (take && cnt_q == '0) state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					val_q    <= value[VW-1:0];
					groups_q <= groups_d;
				end
			end
			E_MARK: begin
				if (take) begin
					val_q <= aligned;
					cnt_q <= len - LW'(1);
				end
			end
			E_BYTES: begin
				if (take) begin
					if (in_value_part) val_q <= val_q << 8;
					cnt_q <= cnt_q - LW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### design/vgc_dec.sv
// ----------------------------------------------------------------------------
// vgc_dec - byte-serial decoder
// Reads preamble and marker, then shifts payload bytes into an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module vgc_dec #(
	parameter int GROUP_BYTES = 4,
	parameter int VALUE_BYTES = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	output logic            res_valid,
	output vgc_pkg::result_t res
);

	localparam int VW = 8 * VALUE_BYTES;

	logic          in_payload_q;
	logic          zero_seen_q;  // any zero preamble byte means overflow
	logic [3:0]    left_q;
	logic [VW-1:0] acc_q;

	logic [VW-1:0] acc_next;
	logic          multi;
	logic          fits;
	logic [3:0]    mark_left;
	logic          overflow;

	always_comb begin
		acc_next  = (acc_q << 8) | VW'(in_byte);
		multi     = ((in_byte & (in_byte - 8'd1)) != 8'h00);
		fits      = 1'b0;
		mark_left = '0;
		for (int i = 0; i < 8; i++) begin
			if (in_byte == (vgc_pkg::MARK_TOP >> i)) begin
				fits      = ((i + 1) * GROUP_BYTES <= VALUE_BYTES);
				mark_left = 4'((i + 1) * GROUP_BYTES);
			end
		end
		overflow = zero_seen_q || !fits;
	end

	always_comb begin
		res_valid     = 1'b0;
		res.kind      = vgc_pkg::KIND_VALUE;
		res.data_byte = 8'h00;
		res.value     = '0;
		res.last      = 1'b1;
		if (step) begin
			if (in_payload_q) begin
				res_valid = (left_q == 4'd1);
				res.value = vgc_pkg::VALUE_W'(acc_next);
			end else if (in_byte != 8'h00) begin
				res_valid = multi || overflow;
				res.kind  = multi ? vgc_pkg::KIND_BAD_MARK : vgc_pkg::KIND_OVERFLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			zero_seen_q  <= 1'b0;
			left_q       <= '0;
		end else if (step) begin
			if (in_payload_q) begin
				left_q <= left_q - 4'd1;
				if (left_q == 4'd1) in_payload_q <= 1'b0;
			end else if (in_byte == 8'h00) begin
				zero_seen_q <= 1'b1;
			end else begin
				zero_seen_q <= 1'b0;
				if (!multi && !overflow) begin
					in_payload_q <= 1'b1;
					left_q       <= mark_left;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (in_payload_q) acc_q <= acc_next;
			else              acc_q <= '0;
		end
	end

endmodule

`default_nettype wire

### design/varint_group_codec.sv
// ----------------------------------------------------------------------------
// varint_group_codec - self-sized unsigned integer codec
// Encodes a value into marker and big-endian payload bytes, and decodes a
// byte stream back into values, with bad-marker and overflow reporting.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------
//  in      | in_valid in_ready operation in_byte       | one word: a wire byte
//          | in_value                                  | or a value to encode
//  out     | out_valid out_ready kind out_byte         | one word: a byte, a
//          | out_value last                            | value or an error
//
//  Decode: one input word a cycle unless the output stalls or an encode runs;
//  a result lands in the output register at the edge the word is taken.
//  Encode: the value is sized as it is taken, then the marker goes out and
//  len = groups * GROUP_BYTES payload bytes follow, one a cycle out of the
//  encoder's byte-wide shift register unless the output stalls. No input is
//  taken meanwhile. Reset clears the decoder back to preamble and empties the
//  output register. A stalled output holds its word; input is taken only when
//  the output register is empty or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_group_codec #(
	parameter int GROUP_BYTES = 4,
	parameter int VALUE_BYTES = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        operation,
	input  wire logic [7:0]                  in_byte,
	input  wire logic [vgc_pkg::VALUE_W-1:0] in_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       kind,
	output logic [7:0]                       out_byte,
	output logic [vgc_pkg::VALUE_W-1:0]      out_value,
	output logic                             last
);

	vgc_pkg::enc_stat_t enc_stat;
	vgc_pkg::result_t   enc_res;
	vgc_pkg::result_t   dec_res;
	vgc_pkg::result_t   out_q;
	logic               dec_valid;
	logic               out_valid_q;

	logic slot_free;   // output register empty or draining this cycle
	logic in_accept;
	logic enc_start;
	logic dec_step;
	logic enc_take;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !enc_stat.busy && slot_free;
	assign in_accept = in_valid && in_ready;
	assign enc_start = in_accept && (operation == vgc_pkg::OP_ENCODE);
	assign dec_step  = in_accept && (operation == vgc_pkg::OP_DECODE);
	// encoder words only move once it owns the slot
	assign enc_take  = enc_stat.valid && slot_free;

	vgc_enc #(
		.GROUP_BYTES(GROUP_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_enc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (enc_start),
		.value (in_value),
		.take  (enc_take),
		.stat  (enc_stat),
		.res   (enc_res)
	);

	vgc_dec #(
		.GROUP_BYTES(GROUP_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (dec_step),
		.in_byte  (in_byte),
		.res_valid(dec_valid),
		.res      (dec_res)
	);

	// output register: decoder and encoder never offer in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= dec_valid || enc_take;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid) begin
			out_q <= dec_res;
		end else if (enc_take) begin
			out_q <= enc_res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign out_byte  = out_q.data_byte;
	assign out_value = out_q.value;
	assign last      = out_q.last;

	// an encode always starts by offering its marker
	a_enc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		enc_start |=> enc_stat.valid)
		else $error("encoder not offering after start");

	// the final payload byte frees the encoder
	a_enc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_take && enc_res.last) |=> !enc_stat.busy)
		else $error("encoder still busy after its last byte");

	// decoder results and errors are single words, always flagged last
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != vgc_pkg::KIND_BYTE) |-> out_q.last)
		else $error("non-byte word without last");

	// the decoder never produces an encoded byte word
	a_dec_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid |-> (dec_res.kind != vgc_pkg::KIND_BYTE))
		else $error("decoder produced a byte word");

endmodule

`default_nettype wire

### bench/varint_group_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_group_codec_test - self-checking bench for the varint group codec
// Feeds encode words and wire-byte streams through valid/ready with random
// idling on both sides. Results are checked word by word against an in-bench
// model of the encoder and the decoder state.
// ----------------------------------------------------------------------------

module varint_group_codec_test;

	localparam int GROUP_BYTES = 4;
	localparam int VALUE_BYTES = 8;
	localparam int RAND_WORDS  = 85;
	localparam int VALUE_W     = vgc_pkg::VALUE_W;

	// one input word as queued for the driver; drain holds it back until
	// every result owed so far has come out
	typedef struct {
		vgc_pkg::op_t       op;
		logic [7:0]         data;
		logic [VALUE_W-1:0] value;
		bit                 drain;
	} in_word_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               operation = 1'b0;
	logic [7:0]         in_byte   = 8'h00;
	logic [VALUE_W-1:0] in_value  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic [7:0]         out_byte;
	logic [VALUE_W-1:0] out_value;
	logic               last;

	in_word_t         pending_words[$];
	vgc_pkg::result_t due_words[$];

	// decoder state as the codec should hold it
	bit                 dec_in_payload;
	logic [7:0]         dec_zero_run;
	logic [3:0]         dec_left;
	logic [VALUE_W-1:0] dec_acc;

	int n_sent, n_taken, n_got, seen_got;
	int send_gap, recv_stall;
	bit send_calm, recv_calm;
	int mismatches;
	int n_encodes, n_fed, n_bytes, n_values, n_bad, n_ovf;

	varint_group_codec #(
		.GROUP_BYTES(GROUP_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.in_byte  (in_byte),
		.in_value (in_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.out_byte (out_byte),
		.out_value(out_value),
		.last     (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- encoding

	// groups needed for a value; bytes above VALUE_BYTES do not count, and
	// zero still takes one significant byte
	function automatic int varint_groups(input logic [VALUE_W-1:0] v);
		int sig;
		sig = 1;
		for (int i = 0; i < VALUE_BYTES; i++)
			if (v[8*i +: 8] != 8'h00)
				sig = i + 1;
		return (sig + GROUP_BYTES - 1) / GROUP_BYTES;
	endfunction

	// whole run on the wire: zero preamble, marker, padded payload
	function automatic int varint_len(input logic [VALUE_W-1:0] v);
		int groups;
		groups = varint_groups(v);
		return (groups - 1) / 8 + 1 + groups * GROUP_BYTES;
	endfunction

	function automatic logic [7:0] varint_byte(input logic [VALUE_W-1:0] v, input int idx);
		int groups, zeros, plen, s;
		groups = varint_groups(v);
		zeros  = (groups - 1) / 8;
		plen   = groups * GROUP_BYTES;
		if (idx < zeros)
			return 8'h00;
		if (idx == zeros)
			return vgc_pkg::MARK_TOP >> ((groups - 1) % 8);
		s = plen - 1 - (idx - zeros - 1);   // big-endian: byte index from the top
		if (s >= VALUE_BYTES)
			return 8'h00;                   // front padding to a whole group
		return v[8*s +: 8];
	endfunction

	// ------------------------------------------------------------- codec model

	function automatic void owe(input vgc_pkg::kind_t k, input logic [7:0] b,
			input logic [VALUE_W-1:0] v, input logic lst);
		vgc_pkg::result_t r;
		r.kind      = k;
		r.data_byte = b;
		r.value     = v;
		r.last      = lst;
		due_words.push_back(r);
	endfunction

	function automatic void dec_back_to_preamble();
		dec_in_payload = 1'b0;
		dec_zero_run   = 8'h00;
		dec_left       = 4'h0;
		dec_acc        = '0;
	endfunction

	// an encode never touches the decoder state
	function automatic void encode_value(input logic [VALUE_W-1:0] v);
		int n;
		n = varint_len(v);
		for (int i = 0; i < n; i++)
			owe(vgc_pkg::KIND_BYTE, varint_byte(v, i), '0, i == n - 1);
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		int pos, plen;
		if (dec_in_payload) begin
			dec_acc  = {dec_acc[VALUE_W-9:0], b};
			dec_left = dec_left - 4'd1;
			if (dec_left == 4'd0) begin
				owe(vgc_pkg::KIND_VALUE, 8'h00, dec_acc, 1'b1);
				dec_back_to_preamble();
			end
		end else if (b == 8'h00) begin
			// preamble zero; the count sticks at 255
			if (dec_zero_run != 8'hFF)
				dec_zero_run = dec_zero_run + 8'd1;
		end else if ((b & (b - 8'd1)) != 8'h00) begin
			owe(vgc_pkg::KIND_BAD_MARK, 8'h00, '0, 1'b1);
			dec_back_to_preamble();
		end else begin
			pos = 1;
			while (b[8 - pos] == 1'b0)
				pos++;
			plen = (int'(dec_zero_run) * 8 + pos) * GROUP_BYTES;
			if (plen > VALUE_BYTES) begin
				owe(vgc_pkg::KIND_OVERFLOW, 8'h00, '0, 1'b1);
				dec_back_to_preamble();
			end else begin
				dec_in_payload = 1'b1;
				dec_left       = plen[3:0];
				dec_acc        = '0;
				dec_zero_run   = 8'h00;
			end
		end
	endfunction

	// ----------------------------------------------------------------- stimulus

	function automatic void add_word(input vgc_pkg::op_t op, input logic [7:0] b,
			input logic [VALUE_W-1:0] v, input bit drain);
		in_word_t w;
		w.op    = op;
		w.data  = b;
		w.value = v;
		w.drain = drain;
		pending_words.push_back(w);
	endfunction

	// value of random size, zero and full width included
	function automatic logic [VALUE_W-1:0] rand_value();
		return {$urandom(), $urandom()} >> (8 * $urandom_range(0, 8));
	endfunction

	// unused fields carry noise so the codec is seen to ignore them
	function automatic void add_encode(input logic [VALUE_W-1:0] v, input bit drain);
		add_word(vgc_pkg::OP_ENCODE, 8'($urandom()), v, drain);
	endfunction

	function automatic void add_byte(input logic [7:0] b, input bit drain);
		add_word(vgc_pkg::OP_DECODE, b, {$urandom(), $urandom()}, drain);
	endfunction

	// well-formed run for v; with mid_encode an encode word is slipped in
	// after the marker, which must not disturb the decode in progress
	function automatic int add_stream(input logic [VALUE_W-1:0] v, input bit mid_encode,
			input bit drain);
		int n;
		n = varint_len(v);
		for (int i = 0; i < n; i++) begin
			add_byte(varint_byte(v, i), drain && i == 0);
			if (mid_encode && i == 0)
				add_encode(rand_value(), 1'b0);
		end
		return n + int'(mid_encode);
	endfunction

	function automatic int pick_idle(inout bit calm);
		if ($urandom_range(0, 11) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	// ------------------------------------------------------------------ checks

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%0t: result %0d: %s got %0h, want %0h", $realtime, n_got, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------ driver

	// words go out at the falling edge; a taken word is seen as n_taken
	// catching up with n_sent
	always @(negedge clk) begin
		in_word_t w;
		if (arst_n && !(in_valid && n_taken != n_sent)) begin
			if (in_valid)
				send_gap = pick_idle(send_calm);
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0 &&
					!(pending_words[0].drain && due_words.size() != 0)) begin
				w = pending_words.pop_front();
				operation <= w.op;
				in_byte   <= w.data;
				in_value  <= w.value;
				in_valid  <= 1'b1;
				n_sent    <= n_sent + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure: a fresh stall drawn for each word taken
	always @(negedge clk) begin
		if (n_got != seen_got) begin
			seen_got   = n_got;
			recv_stall = pick_idle(recv_calm);
		end
		if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ----------------------------------------------------------------- monitor

	// model first, then the output: a decode result cannot leave at the
	// edge its input word is taken, so the order is safe either way
	always @(posedge clk) begin
		vgc_pkg::result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_taken <= n_taken + 1;
				if (operation == vgc_pkg::OP_ENCODE) begin
					n_encodes++;
					encode_value(in_value);
				end else begin
					n_fed++;
					decode_byte(in_byte);
				end
			end
			if (out_valid && out_ready) begin
				n_got <= n_got + 1;
				if (due_words.size() == 0) begin
					report_mismatch("unexpected word, kind", VALUE_W'(kind), '0);
				end else begin
					want = due_words.pop_front();
					if (kind != want.kind)
						report_mismatch("kind", VALUE_W'(kind), VALUE_W'(want.kind));
					if (out_byte != want.data_byte)
						report_mismatch("out_byte", VALUE_W'(out_byte),
							VALUE_W'(want.data_byte));
					if (out_value != want.value)
						report_mismatch("out_value", out_value, want.value);
					if (last != want.last)
						report_mismatch("last", VALUE_W'(last), VALUE_W'(want.last));
					case (want.kind)
						vgc_pkg::KIND_BYTE:     n_bytes++;
						vgc_pkg::KIND_VALUE:    n_values++;
						vgc_pkg::KIND_BAD_MARK: n_bad++;
						vgc_pkg::KIND_OVERFLOW: n_ovf++;
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------- run

	initial begin
		int counted;
		dec_back_to_preamble();

		// directed: value widths at the group boundary and the extremes
		add_encode(64'h0, 1'b0);
		add_encode(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_encode(64'h0000_0001_0000_0000, 1'b0);
		add_encode(64'h0000_0000_FFFF_FFFF, 1'b0);
		// several marker bits, marker too far down, preamble zero then marker
		add_byte(8'hFF, 1'b0);
		add_byte(8'h20, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h80, 1'b0);
		// one-group payload, with an encode between its marker and its bytes
		add_byte(8'h80, 1'b0);
		add_encode(64'd12345, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h01, 1'b0);
		// two-group payload, every in_byte bit both ways
		add_byte(8'h40, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'hFE, 1'b0);

		// random: mostly well-formed streams and encodes, some noise and
		// broken runs; the first word waits for the directed part to drain
		counted = 0;
		while (counted < RAND_WORDS) begin
			bit drain;
			drain = (counted == 0) || ($urandom_range(0, 19) == 0);
			case ($urandom_range(0, 9)) inside
				[0:2]: begin
					add_encode(rand_value(), drain);
					counted++;
				end
				8: begin
					add_byte(8'($urandom()), drain);
					counted++;
				end
				9: begin
					case ($urandom_range(0, 2))
						0: begin
							// zeros ahead of the marker always overflow
							repeat ($urandom_range(1, 2))
								add_byte(8'h00, 1'b0);
							add_byte(vgc_pkg::MARK_TOP >> $urandom_range(0, 7), drain);
						end
						1:  add_byte(8'h03 << $urandom_range(0, 6), drain);
						default: add_byte(vgc_pkg::MARK_TOP >> $urandom_range(2, 7), drain);
					endcase
					counted++;
				end
				default:
					counted += add_stream(rand_value(), $urandom_range(0, 3) == 0, drain);
			endcase
		end

		// a few preamble zeros ahead of a top marker overflow, then a clean stream
		repeat (3)
			add_byte(8'h00, 1'b0);
		add_byte(8'h80, 1'b0);
		void'(add_stream(rand_value(), 1'b0, 1'b0));

		repeat (3) @(posedge clk);
		#2 arst_n = 1'b1;

		while (pending_words.size() != 0 || in_valid || due_words.size() != 0)
			@(posedge clk);
		// longest encode is well under this; anything late shows as unexpected
		repeat (20) @(posedge clk);

		$display("Fed %0d words: %0d encodes and %0d wire bytes to the decoder.",
			n_taken, n_encodes, n_fed);
		$display("Checked %0d encoded bytes, %0d values, %0d bad markers, %0d overflows.",
			n_bytes, n_values, n_bad, n_ovf);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout: %0d words still queued, %0d results outstanding",
			pending_words.size(), due_words.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
